// ----- sv/fpa_pkg.sv -----
package fpa_pkg;

  localparam int MAX_PROCS = 16;
  localparam int MAX_HOLES = 17;
  localparam int PID_LIMIT = 256;

  localparam int PAGE_W = 16;
  localparam int PSZ_W = 13;
  localparam int ADDR_W = 28;
  localparam int PID_W = 8;
  localparam int ALU_W = 21;

  localparam int AI_W = $clog2(MAX_PROCS);
  localparam int AC_W = $clog2(MAX_PROCS + 1);
  localparam int HC_W = $clog2(MAX_HOLES + 1);
  localparam int CNT_AW = $clog2(PID_LIMIT);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic [2:0] K_GRANTED = 3'd0;
  localparam logic [2:0] K_REJECTED = 3'd1;
  localparam logic [2:0] K_RELOCATED = 3'd2;
  localparam logic [2:0] K_READ_OK = 3'd3;
  localparam logic [2:0] K_WRITE_OK = 3'd4;
  localparam logic [2:0] K_WRITE_REFUSED = 3'd5;
  localparam logic [2:0] K_NOT_FOUND = 3'd6;
  localparam logic [2:0] K_RELEASED = 3'd7;

  localparam logic REG_TOTAL_PAGES = 1'b0;
  localparam logic REG_PAGE_SIZE = 1'b1;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic lt;
    logic eq;
  } alu_rsp_t;

endpackage

// ----- sv/fpa_ram.sv -----
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fpa_alu.sv -----
module fpa_alu import fpa_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  // One adder/subtractor shared by several steps of the sequencer.
  always_comb begin
    rsp.res = (req.op == ALU_ADD) ? req.a + req.b : req.a - req.b;
    rsp.lt = req.a < req.b;
    rsp.eq = req.a == req.b;
  end

endmodule

// ----- sv/first_fit_page_allocator.sv -----
// Allocate sums the free pages over all holes, walks the holes first-fit and updates the
// hole it takes; when no hole fits, it compacts the area once and walks the holes again.
// Read and write look the pid up in the allocation list, then form the byte address;
// release looks the pid up, closes its gap in the allocation list, then visits the holes
// to merge the freed region into a neighbor or append it. All steps share one adder.
// Throughput: one item at a time; the next item is taken once the last result is loaded.
// Reset is synchronous: one hole covering the whole area, empty lists, counters at zero.
module first_fit_page_allocator import fpa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pid[7:0], page_count[23:8], page_index[39:24], data_length[52:40], zeros above
  input  logic [55:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pid[7:0], start_page[23:8], old_start[39:24], pages[55:40],
  // byte_address[83:56], reads_done[99:84], writes_done[115:100], zeros above
  output logic [119:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]   m_axis_tuser,
  // last
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  // The sequencer walks the hole and allocation tables one entry at a time.
  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_SUM     = 25'h0000002,
    S_CHK     = 25'h0000004,
    S_FIT     = 25'h0000008,
    S_TAKE    = 25'h0000010,
    S_TAKE2   = 25'h0000020,
    S_HSH     = 25'h0000040,
    S_GRANT   = 25'h0000080,
    S_REJ     = 25'h0000100,
    S_CSEL    = 25'h0000200,
    S_CEMIT   = 25'h0000400,
    S_CADD    = 25'h0000800,
    S_CFIN    = 25'h0001000,
    S_FIND    = 25'h0002000,
    S_NF      = 25'h0004000,
    S_RW1     = 25'h0008000,
    S_RW2     = 25'h0010000,
    S_RW3     = 25'h0020000,
    S_RWEMIT  = 25'h0040000,
    S_REL0    = 25'h0080000,
    S_ASH     = 25'h0100000,
    S_HM1     = 25'h0200000,
    S_HM2     = 25'h0400000,
    S_HM3     = 25'h0800000,
    S_RELEMIT = 25'h1000000
  } state_t;

  state_t state;

  logic [PAGE_W-1:0] total_pages;
  logic [PSZ_W-1:0]  page_size;

  // Hole and allocation tables.
  logic [PAGE_W-1:0] hs [MAX_HOLES];
  logic [PAGE_W-1:0] hp [MAX_HOLES];
  logic [HC_W-1:0]   hc;
  logic [PID_W-1:0]  ap [MAX_PROCS];
  logic [PAGE_W-1:0] ast [MAX_PROCS];
  logic [PAGE_W-1:0] apg [MAX_PROCS];
  logic [AC_W-1:0]   ac;

  // Latched request.
  logic [1:0]        op;
  logic [PID_W-1:0]  pid;
  logic [PAGE_W-1:0] cnt;
  logic [PAGE_W-1:0] pidx;
  logic [PSZ_W-1:0]  dlen;

  // Working registers.
  logic [HC_W-1:0]      hi;
  logic [AC_W-1:0]      ai;
  logic [ALU_W-1:0]     freep;
  logic                 compacted;
  logic [MAX_PROCS-1:0] done;
  logic [AI_W-1:0]      best;
  logic [PAGE_W-1:0]    bstart;
  logic                 bvalid;
  logic [19:0]          packed_pg;
  logic [PAGE_W-1:0]    sreg;
  logic [PAGE_W-1:0]    pgr;
  logic                 wok;
  logic [16:0]          sum17;
  logic [16:0]          spg;
  logic [16:0]          endr;
  logic [16:0]          sumr;
  logic                 hit1;
  logic                 hit2;
  logic [29:0]          prod;

  // Per-pid counters live in RAM; a valid bit per pid stands for the cleared state.
  logic [PID_LIMIT-1:0] cvalid;
  logic [CNT_AW-1:0]    c_raddr;
  logic                 c_we;
  logic [15:0]          rc_wdata, wc_wdata, rc_rdata, wc_rdata;
  logic [15:0]          rc, wc, rd_new, wr_new;
  logic [2:0]           rw_kind;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic out_free;

  fpa_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  fpa_ram #(.WIDTH(16), .DEPTH(PID_LIMIT)) u_rd_ram (
    .clk(clk), .we(c_we), .waddr(pid), .wdata(rc_wdata), .raddr(c_raddr), .rdata(rc_rdata)
  );

  fpa_ram #(.WIDTH(16), .DEPTH(PID_LIMIT)) u_wr_ram (
    .clk(clk), .we(c_we), .waddr(pid), .wdata(wc_wdata), .raddr(c_raddr), .rdata(wc_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // The read address follows the incoming pid while idle so the data is ready on entry.
  assign c_raddr = (state == S_IDLE) ? s_axis_tdata[7:0] : pid;
  assign rc = cvalid[pid] ? rc_rdata : 16'd0;
  assign wc = cvalid[pid] ? wc_rdata : 16'd0;

  always_comb begin
    rd_new = rc;
    wr_new = wc;
    if (op == OP_READ) begin
      rd_new = (rc == 16'hFFFF) ? rc : rc + 16'd1;
      rw_kind = K_READ_OK;
    end else if (wok) begin
      wr_new = (wc == 16'hFFFF) ? wc : wc + 16'd1;
      rw_kind = K_WRITE_OK;
    end else begin
      rw_kind = K_WRITE_REFUSED;
    end
  end

  always_comb begin
    c_we = 1'b0;
    rc_wdata = rd_new;
    wc_wdata = wr_new;
    if (state == S_RWEMIT && out_free) begin
      c_we = 1'b1;
    end else if (state == S_RELEMIT && out_free) begin
      c_we = 1'b1;
      rc_wdata = 16'd0;
      wc_wdata = 16'd0;
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a = '0;
    alu_req.b = '0;
    case (state)
      S_SUM: begin
        alu_req.a = freep;
        alu_req.b = ALU_W'(hp[hi]);
      end
      S_CHK: begin
        alu_req.op = ALU_SUB;
        alu_req.a = freep;
        alu_req.b = ALU_W'(cnt);
      end
      S_FIT, S_TAKE: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(hp[hi]);
        alu_req.b = ALU_W'(cnt);
      end
      S_TAKE2: begin
        alu_req.a = ALU_W'(hs[hi]);
        alu_req.b = ALU_W'(cnt);
      end
      S_CSEL: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(ast[ai[AI_W-1:0]]);
        alu_req.b = ALU_W'(bstart);
      end
      S_CADD: begin
        alu_req.a = ALU_W'(packed_pg);
        alu_req.b = ALU_W'(apg[best]);
      end
      S_CFIN: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(total_pages);
        alu_req.b = ALU_W'(packed_pg);
      end
      S_RW1: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(dlen);
        alu_req.b = ALU_W'(page_size);
      end
      S_RW2: begin
        alu_req.a = ALU_W'(sreg);
        alu_req.b = ALU_W'(pidx);
      end
      S_REL0: begin
        alu_req.a = ALU_W'(sreg);
        alu_req.b = ALU_W'(pgr);
      end
      S_HM1: begin
        alu_req.a = ALU_W'(hs[hi]);
        alu_req.b = ALU_W'(hp[hi]);
      end
      S_HM2: begin
        alu_req.a = ALU_W'(hp[hi]);
        alu_req.b = ALU_W'(pgr);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total_pages <= 16'd256;
      page_size <= 13'd256;
      hs[0] <= '0;
      hp[0] <= 16'd256;
      hc <= HC_W'(1);
      ac <= '0;
      cvalid <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_PAGES) begin
          total_pages <= cfg_data;
        end else begin
          page_size <= cfg_data[PSZ_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op <= s_axis_tuser;
            pid <= s_axis_tdata[7:0];
            cnt <= s_axis_tdata[23:8];
            pidx <= s_axis_tdata[39:24];
            dlen <= s_axis_tdata[52:40];
            compacted <= 1'b0;
            hi <= '0;
            ai <= '0;
            freep <= '0;
            state <= (s_axis_tuser == OP_ALLOC) ? S_SUM : S_FIND;
          end
        end
        S_SUM: begin
          if (hi < hc) begin
            freep <= alu_rsp.res;
            hi <= hi + HC_W'(1);
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          hi <= '0;
          if (ac >= AC_W'(MAX_PROCS) || alu_rsp.lt) begin
            state <= S_REJ;
          end else begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (hi < hc) begin
            if (!alu_rsp.lt) begin
              state <= S_TAKE;
            end else begin
              hi <= hi + HC_W'(1);
            end
          end else if (!compacted) begin
            ai <= '0;
            done <= '0;
            packed_pg <= '0;
            bvalid <= 1'b0;
            state <= S_CSEL;
          end else begin
            state <= S_REJ;
          end
        end
        S_TAKE: begin
          sreg <= hs[hi];
          if (alu_rsp.eq) begin
            state <= S_HSH;
          end else begin
            hp[hi] <= alu_rsp.res[PAGE_W-1:0];
            state <= S_TAKE2;
          end
        end
        S_TAKE2: begin
          hs[hi] <= alu_rsp.res[PAGE_W-1:0];
          state <= S_GRANT;
        end
        S_HSH: begin
          // An exactly used hole is removed by moving the later holes down.
          if ((hi + HC_W'(1)) < hc) begin
            hs[hi] <= hs[hi + HC_W'(1)];
            hp[hi] <= hp[hi + HC_W'(1)];
            hi <= hi + HC_W'(1);
          end else begin
            hc <= hc - HC_W'(1);
            state <= S_GRANT;
          end
        end
        S_GRANT: begin
          if (out_free) begin
            ap[ac[AI_W-1:0]] <= pid;
            ast[ac[AI_W-1:0]] <= sreg;
            apg[ac[AI_W-1:0]] <= cnt;
            ac <= ac + AC_W'(1);
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= K_GRANTED;
            m_axis_tdata <= {4'd0, 16'd0, 16'd0, 28'd0, cnt, 16'd0, sreg, pid};
            m_axis_tlast <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_REJ: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= K_REJECTED;
            m_axis_tdata <= {112'd0, pid};
            m_axis_tlast <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CSEL: begin
          // Pick the lowest start among the processes not yet packed.
          if (ai < ac) begin
            if (!done[ai[AI_W-1:0]] && (!bvalid || alu_rsp.lt)) begin
              best <= ai[AI_W-1:0];
              bstart <= ast[ai[AI_W-1:0]];
              bvalid <= 1'b1;
            end
            ai <= ai + AC_W'(1);
          end else if (bvalid) begin
            state <= S_CEMIT;
          end else begin
            state <= S_CFIN;
          end
        end
        S_CEMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= K_RELOCATED;
            m_axis_tdata <= {4'd0, 16'd0, 16'd0, 28'd0, apg[best], ast[best],
                             packed_pg[PAGE_W-1:0], ap[best]};
            m_axis_tlast <= 1'b0;
            ast[best] <= packed_pg[PAGE_W-1:0];
            done[best] <= 1'b1;
            state <= S_CADD;
          end
        end
        S_CADD: begin
          packed_pg <= alu_rsp.res[19:0];
          ai <= '0;
          bvalid <= 1'b0;
          state <= S_CSEL;
        end
        S_CFIN: begin
          // All free space becomes one tail hole, empty if the area is overbooked.
          hs[0] <= packed_pg[PAGE_W-1:0];
          hp[0] <= (alu_rsp.lt || alu_rsp.eq) ? '0 : alu_rsp.res[PAGE_W-1:0];
          hc <= HC_W'(1);
          compacted <= 1'b1;
          hi <= '0;
          state <= S_FIT;
        end
        S_FIND: begin
          if (ai < ac) begin
            if (ap[ai[AI_W-1:0]] == pid) begin
              sreg <= ast[ai[AI_W-1:0]];
              pgr <= apg[ai[AI_W-1:0]];
              state <= (op == OP_RELEASE) ? S_REL0 : S_RW1;
            end else begin
              ai <= ai + AC_W'(1);
            end
          end else begin
            state <= S_NF;
          end
        end
        S_NF: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= K_NOT_FOUND;
            m_axis_tdata <= {112'd0, pid};
            m_axis_tlast <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RW1: begin
          wok <= alu_rsp.lt;
          state <= S_RW2;
        end
        S_RW2: begin
          sum17 <= alu_rsp.res[16:0];
          state <= S_RW3;
        end
        S_RW3: begin
          prod <= 30'(sum17) * 30'(page_size);
          state <= S_RWEMIT;
        end
        S_RWEMIT: begin
          if (out_free) begin
            cvalid[pid] <= 1'b1;
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= rw_kind;
            m_axis_tdata <= {4'd0, wr_new, rd_new, prod[ADDR_W-1:0], pgr, 16'd0, sreg, pid};
            m_axis_tlast <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_REL0: begin
          spg <= alu_rsp.res[16:0];
          prod <= 30'(sreg) * 30'(page_size);
          state <= S_ASH;
        end
        S_ASH: begin
          if ((ai + AC_W'(1)) < ac) begin
            ap[ai[AI_W-1:0]] <= ap[ai[AI_W-1:0] + AI_W'(1)];
            ast[ai[AI_W-1:0]] <= ast[ai[AI_W-1:0] + AI_W'(1)];
            apg[ai[AI_W-1:0]] <= apg[ai[AI_W-1:0] + AI_W'(1)];
            ai <= ai + AC_W'(1);
          end else begin
            ac <= ac - AC_W'(1);
            hi <= '0;
            state <= S_HM1;
          end
        end
        S_HM1: begin
          if (hi < hc) begin
            endr <= alu_rsp.res[16:0];
            state <= S_HM2;
          end else begin
            // No neighbor hole: append one if the table has room.
            if (hc < HC_W'(MAX_HOLES)) begin
              hs[hc] <= sreg;
              hp[hc] <= pgr;
              hc <= hc + HC_W'(1);
            end
            state <= S_RELEMIT;
          end
        end
        S_HM2: begin
          sumr <= alu_rsp.res[16:0];
          hit1 <= ({1'b0, sreg} == endr);
          hit2 <= ({1'b0, hs[hi]} == spg);
          state <= S_HM3;
        end
        S_HM3: begin
          if (hit1) begin
            hp[hi] <= sumr[16] ? 16'hFFFF : sumr[15:0];
            state <= S_RELEMIT;
          end else if (hit2) begin
            hs[hi] <= sreg;
            hp[hi] <= sumr[16] ? 16'hFFFF : sumr[15:0];
            state <= S_RELEMIT;
          end else begin
            hi <= hi + HC_W'(1);
            state <= S_HM1;
          end
        end
        S_RELEMIT: begin
          if (out_free) begin
            cvalid[pid] <= 1'b1;
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= K_RELEASED;
            m_axis_tdata <= {4'd0, wc, rc, prod[ADDR_W-1:0], pgr, sreg, 16'd0, pid};
            m_axis_tlast <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_hole_bound: assert property (@(posedge clk) disable iff (rst)
    hc <= HC_W'(MAX_HOLES))
    else $error("hole count beyond table size");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    ac <= AC_W'(MAX_PROCS))
    else $error("allocation count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != S_IDLE)
    else $error("accepted item did not start the sequencer");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result overwritten");

endmodule

// ----- sim/fpa_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams and the register port of the page allocator, keeps
// its own copy of the hole list, the allocation list and the per-pid access
// counters, and compares every result item against the oldest prediction.
module fpa_checker import fpa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pid;
    logic [15:0] start;
    logic [15:0] old;
    logic [15:0] pages;
    logic [27:0] addr;
    logic [15:0] rd;
    logic [15:0] wr;
    logic        last;
  } result_t;

  result_t     result_q[$];
  logic [15:0] area_pages;
  logic [12:0] bytes_per_page;
  logic [15:0] h_start[MAX_HOLES];
  logic [15:0] h_pages[MAX_HOLES];
  int          h_cnt;
  logic [7:0]  a_pid[MAX_PROCS];
  logic [15:0] a_start[MAX_PROCS];
  logic [15:0] a_pages[MAX_PROCS];
  int          a_cnt;
  logic [15:0] rd_cnt[PID_LIMIT];
  logic [15:0] wr_cnt[PID_LIMIT];

  assign pending = result_q.size();

  function automatic result_t mk(logic [2:0] k, logic [7:0] p, logic [15:0] s,
                                 logic [15:0] o, logic [15:0] n, logic [27:0] a,
                                 logic [15:0] r, logic [15:0] w, logic l);
    result_t x;
    x = '{k, p, s, o, n, a, r, w, l};
    return x;
  endfunction

  function automatic int first_fit(logic [15:0] cnt);
    for (int i = 0; i < h_cnt; i++)
      if (h_pages[i] >= cnt) return i;
    return -1;
  endfunction

  // Packs every process from page 0 in ascending start order, one relocation each.
  task automatic compact_area();
    bit done[MAX_PROCS];
    int best;
    logic [31:0] packed_pages;
    packed_pages = 0;
    for (int i = 0; i < MAX_PROCS; i++) done[i] = 0;
    for (int n = 0; n < a_cnt; n++) begin
      best = -1;
      for (int j = 0; j < a_cnt; j++)
        if (!done[j] && (best < 0 || a_start[j] < a_start[best])) best = j;
      done[best] = 1;
      result_q.push_back(mk(K_RELOCATED, a_pid[best], packed_pages[15:0],
                            a_start[best], a_pages[best], '0, '0, '0, 1'b0));
      a_start[best] = packed_pages[15:0];
      packed_pages += 32'(a_pages[best]);
    end
    h_start[0] = packed_pages[15:0];
    h_pages[0] = (32'(area_pages) > packed_pages) ? 16'(32'(area_pages) - packed_pages)
                                                   : 16'd0;
    h_cnt = 1;
  endtask

  task automatic predict_request(logic [1:0] op, logic [7:0] pid, logic [15:0] cnt,
                                 logic [15:0] idx, logic [12:0] dlen);
    logic [31:0] free_pages, sum;
    logic [15:0] s, pg, r, w;
    logic [63:0] addr;
    logic [2:0]  kind;
    int h, p, i;
    if (op == OP_ALLOC) begin
      free_pages = 0;
      for (i = 0; i < h_cnt; i++) free_pages += 32'(h_pages[i]);
      if (a_cnt >= MAX_PROCS || free_pages < 32'(cnt)) begin
        result_q.push_back(mk(K_REJECTED, pid, '0, '0, '0, '0, '0, '0, 1'b1));
        return;
      end
      h = first_fit(cnt);
      if (h < 0) begin
        compact_area();
        h = first_fit(cnt);
        if (h < 0) begin
          result_q.push_back(mk(K_REJECTED, pid, '0, '0, '0, '0, '0, '0, 1'b1));
          return;
        end
      end
      s = h_start[h];
      if (h_pages[h] != cnt) begin
        h_start[h] = s + cnt;
        h_pages[h] = h_pages[h] - cnt;
      end else begin
        for (i = h; i + 1 < h_cnt; i++) begin
          h_start[i] = h_start[i + 1];
          h_pages[i] = h_pages[i + 1];
        end
        h_cnt--;
      end
      a_pid[a_cnt] = pid;
      a_start[a_cnt] = s;
      a_pages[a_cnt] = cnt;
      a_cnt++;
      result_q.push_back(mk(K_GRANTED, pid, s, '0, cnt, '0, '0, '0, 1'b1));
      return;
    end
    p = -1;
    for (i = 0; i < a_cnt; i++)
      if (p < 0 && a_pid[i] == pid) p = i;
    if (p < 0) begin
      result_q.push_back(mk(K_NOT_FOUND, pid, '0, '0, '0, '0, '0, '0, 1'b1));
      return;
    end
    s = a_start[p];
    pg = a_pages[p];
    if (op != OP_RELEASE) begin
      addr = (64'(s) + 64'(idx)) * 64'(bytes_per_page);
      kind = K_READ_OK;
      if (op == OP_READ) begin
        if (rd_cnt[pid] != 16'hFFFF) rd_cnt[pid]++;
      end else if (dlen < bytes_per_page) begin
        kind = K_WRITE_OK;
        if (wr_cnt[pid] != 16'hFFFF) wr_cnt[pid]++;
      end else begin
        kind = K_WRITE_REFUSED;
      end
      result_q.push_back(mk(kind, pid, s, '0, pg, addr[27:0], rd_cnt[pid], wr_cnt[pid],
                            1'b1));
      return;
    end
    for (i = p; i + 1 < a_cnt; i++) begin
      a_pid[i] = a_pid[i + 1];
      a_start[i] = a_start[i + 1];
      a_pages[i] = a_pages[i + 1];
    end
    a_cnt--;
    // The freed region joins the first hole it touches, else becomes a new hole
    // unless the hole table is already full. Region ends are compared unwrapped.
    for (i = 0; i < h_cnt; i++) begin
      sum = 32'(h_pages[i]) + 32'(pg);
      if (17'(s) == 17'(h_start[i]) + 17'(h_pages[i])) begin
        h_pages[i] = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
        break;
      end
      if (17'(h_start[i]) == 17'(s) + 17'(pg)) begin
        h_start[i] = s;
        h_pages[i] = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
        break;
      end
    end
    if (i >= h_cnt && h_cnt < MAX_HOLES) begin
      h_start[h_cnt] = s;
      h_pages[h_cnt] = pg;
      h_cnt++;
    end
    r = rd_cnt[pid];
    w = wr_cnt[pid];
    rd_cnt[pid] = 16'd0;
    wr_cnt[pid] = 16'd0;
    addr = 64'(s) * 64'(bytes_per_page);
    result_q.push_back(mk(K_RELEASED, pid, '0, s, pg, addr[27:0], r, w, 1'b1));
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      area_pages = 256;
      bytes_per_page = 256;
      h_start[0] = 0;
      h_pages[0] = 256;
      h_cnt = 1;
      a_cnt = 0;
      for (int i = 0; i < PID_LIMIT; i++) begin
        rd_cnt[i] = 0;
        wr_cnt[i] = 0;
      end
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL_PAGES) area_pages = cfg_data;
        else bytes_per_page = cfg_data[12:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                        s_axis_tdata[39:24], s_axis_tdata[52:40]);
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8],
                 m_axis_tdata[39:24], m_axis_tdata[55:40], m_axis_tdata[83:56],
                 m_axis_tdata[99:84], m_axis_tdata[115:100], m_axis_tlast);
        if (result_q.size() == 0) begin
          report("unexpected item", 64'(got.kind), 0);
        end else begin
          want = result_q.pop_front();
          if (got.kind != want.kind) report("kind", got.kind, want.kind);
          if (got.pid != want.pid) report("out_pid", got.pid, want.pid);
          if (got.start != want.start) report("start_page", got.start, want.start);
          if (got.old != want.old) report("old_start", got.old, want.old);
          if (got.pages != want.pages) report("pages", got.pages, want.pages);
          if (got.addr != want.addr) report("byte_address", got.addr, want.addr);
          if (got.rd != want.rd) report("reads_done", got.rd, want.rd);
          if (got.wr != want.wr) report("writes_done", got.wr, want.wr);
          if (got.last != want.last) report("last", got.last, want.last);
        end
      end
    end
  end

endmodule

// ----- sim/tb_first_fit_page_allocator.sv -----
`timescale 1ns / 100ps

// Top of the allocator testbench. It drives requests and register writes,
// applies back-pressure on the result stream, and gives the verdict. All
// prediction and comparison lives in the checker instance beside the block.
module tb_first_fit_page_allocator;
  import fpa_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // pid[7:0], page_count[23:8], page_index[39:24], data_length[52:40], zeros above
  logic [55:0]  s_axis_tdata;
  // op[1:0]
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // out_pid[7:0], start_page[23:8], old_start[39:24], pages[55:40],
  // byte_address[83:56], reads_done[99:84], writes_done[115:100], zeros above
  logic [119:0] m_axis_tdata;
  // kind[2:0]
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we;
  logic         cfg_index;
  logic [15:0]  cfg_data;
  int           errors;
  int           pending;
  int           idle_cycles;
  bit           long_hold;
  bit           timed_out;

  // A small pool of pids keeps lookups hitting existing allocations most of
  // the time; the rest are random pids that mostly miss.
  logic [7:0]   pid_pool[6] = '{8'd0, 8'd1, 8'd7, 8'd128, 8'd200, 8'd255};

  first_fit_page_allocator i_dut (.*);

  fpa_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither stream moves an item. The long
  // hold-off below is far shorter than this limit.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: its own stall pattern, with a long hold-off when asked.
  initial begin
    int hold;
    m_axis_tready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      hold = $urandom_range(0, 3);
      if (hold == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offers one request and holds it until it is taken. The block is busy in
  // the cycle after an accept, so the idle cycle that follows costs nothing.
  task automatic send_request(logic [1:0] op, logic [7:0] pid, logic [15:0] cnt,
                              logic [15:0] idx, logic [12:0] dlen);
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b0, dlen, idx, cnt, pid};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every result, then lets the block settle before register writes.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: allocations of small sizes, accesses and
  // releases on pool pids, with occasional full-range noise.
  task automatic random_requests(int n, int max_pages);
    int burst;
    logic [1:0] op;
    logic [7:0] pid;
    logic [15:0] cnt, idx;
    logic [12:0] dlen;
    while (n > 0) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst && n > 0; b++) begin
        op = 2'($urandom_range(0, 3));
        pid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pid_pool[$urandom_range(0, 5)];
        cnt = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, max_pages));
        idx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
        dlen = ($urandom_range(0, 5) == 0) ? 13'($urandom) : 13'($urandom_range(0, 300));
        send_request(op, pid, cnt, idx, dlen);
        n--;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_ALLOC;
    cfg_we <= 1'b0;
    cfg_index <= REG_TOTAL_PAGES;
    cfg_data <= '0;
    long_hold = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fragment the area, then force a compaction, rejected
    // allocations, duplicate pids, unknown pids and the write length limit.
    send_request(OP_ALLOC, 8'd1, 16'd60, 0, 0);
    send_request(OP_ALLOC, 8'd2, 16'd60, 0, 0);
    send_request(OP_ALLOC, 8'd3, 16'd60, 0, 0);
    send_request(OP_ALLOC, 8'd1, 16'd0, 0, 0);
    send_request(OP_RELEASE, 8'd2, 0, 0, 0);
    send_request(OP_ALLOC, 8'd4, 16'd100, 0, 0);
    send_request(OP_READ, 8'd3, 0, 16'hFFFF, 0);
    send_request(OP_WRITE, 8'd3, 0, 16'd2, 13'd255);
    send_request(OP_WRITE, 8'd3, 0, 16'd2, 13'd256);
    send_request(OP_WRITE, 8'd3, 0, 16'd2, 13'h1FFF);
    send_request(OP_READ, 8'd99, 0, 0, 0);
    send_request(OP_RELEASE, 8'd99, 0, 0, 0);
    send_request(OP_ALLOC, 8'd255, 16'hFFFF, 0, 0);
    send_request(OP_ALLOC, 8'd5, 16'd40, 0, 0);
    send_request(OP_RELEASE, 8'd3, 0, 0, 0);
    send_request(OP_RELEASE, 8'd1, 0, 0, 0);
    send_request(OP_RELEASE, 8'd1, 0, 0, 0);
    // Fill the allocation table past its limit.
    for (int i = 0; i < 17; i++) send_request(OP_ALLOC, 8'(10 + i), 16'd1, 0, 0);

    // Sender pauses until everything has come back, then registers change.
    drain();
    write_reg(REG_TOTAL_PAGES, 16'hFFFF);
    write_reg(REG_PAGE_SIZE, 16'd4096);
    for (int i = 0; i < 16; i++) send_request(OP_RELEASE, 8'(10 + i), 0, 0, 0);
    send_request(OP_RELEASE, 8'd4, 0, 0, 0);
    send_request(OP_RELEASE, 8'd5, 0, 0, 0);
    random_requests(40, 40);

    // Long receiver hold-off while requests keep coming.
    long_hold = 1;
    random_requests(20, 40);
    drain();
    write_reg(REG_TOTAL_PAGES, 16'd1);
    write_reg(REG_PAGE_SIZE, 16'd1);
    random_requests(30, 2);
    drain();
    write_reg(REG_TOTAL_PAGES, 16'd300);
    write_reg(REG_PAGE_SIZE, 16'd257);
    random_requests(40, 30);
    drain();
    write_reg(REG_TOTAL_PAGES, 16'd256);
    write_reg(REG_PAGE_SIZE, 16'd256);
    random_requests(28, 60);

    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
